>>> design/b64sd_pkg.sv
package b64sd_pkg;

  localparam int unsigned SextetW = 6;
  localparam int unsigned AccW    = 3 * SextetW;
  localparam int unsigned TripleW = 4 * SextetW;
  localparam logic [7:0]  PadChar = 8'h3D;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_LEN  = 2'd2
  } status_e;

  // results of one decoded character, handed to the output buffer
  typedef struct packed {
    logic [TripleW-1:0] triple;
    logic [1:0]         count;
    logic               msg_end;
    status_e            status;
  } res_bundle_t;

  // alphabet lookup: bit 6 flags a byte outside the alphabet, '=' maps to zero
  function automatic logic [SextetW:0] sextet_of(input logic [7:0] c);
    logic [SextetW:0] r;
    r = {1'b1, {SextetW{1'b0}}};
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b0, 6'd63};
    end else if (c == PadChar) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

>>> design/b64sd_quad_core.sv
module b64sd_quad_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [7:0]              char_code_i,
  input  logic                    last_char_i,
  input  logic                    fire_i,
  output b64sd_pkg::res_bundle_t  res_o
);
  import b64sd_pkg::*;

  logic [AccW-1:0] acc_q, acc_d;
  logic [1:0]      pos_q, pos_d;
  logic            third_pad_q, third_pad_d;
  logic            bad_q, bad_d;
  logic            disc_q, disc_d;

  logic [SextetW:0]   map;
  logic [SextetW-1:0] sx;
  logic               bad_n;
  logic               is_pad;

  always_comb begin
    map    = sextet_of(char_code_i);
    sx     = map[SextetW] ? '0 : map[SextetW-1:0];
    bad_n  = bad_q | map[SextetW];
    is_pad = (char_code_i == PadChar);

    acc_d       = acc_q;
    pos_d       = pos_q;
    third_pad_d = third_pad_q;
    bad_d       = bad_q;
    disc_d      = disc_q;

    res_o.triple  = '0;
    res_o.count   = 2'd0;
    res_o.msg_end = 1'b0;
    res_o.status  = ST_OK;

    if (disc_q) begin
      // drop the rest of a failed message
      if (last_char_i) begin
        disc_d = 1'b0;
      end
    end else if (pos_q != 2'd3) begin
      acc_d = {acc_q[AccW-SextetW-1:0], sx};
      pos_d = pos_q + 2'd1;
      bad_d = bad_n;
      if (pos_q == 2'd2) begin
        third_pad_d = is_pad;
      end
      if (last_char_i) begin
        res_o.count   = 2'd1;
        res_o.msg_end = 1'b1;
        res_o.status  = ST_BAD_LEN;
        acc_d         = '0;
        pos_d         = 2'd0;
        third_pad_d   = 1'b0;
        bad_d         = 1'b0;
      end
    end else begin
      acc_d       = '0;
      pos_d       = 2'd0;
      third_pad_d = 1'b0;
      bad_d       = 1'b0;
      if (bad_n) begin
        res_o.count   = 2'd1;
        res_o.msg_end = 1'b1;
        res_o.status  = ST_BAD_CHAR;
        disc_d        = !last_char_i;
      end else begin
        res_o.triple  = {acc_q, sx};
        res_o.msg_end = last_char_i;
        res_o.count   = 2'd3 - {1'b0, last_char_i & is_pad}
                             - {1'b0, last_char_i & third_pad_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pos_q       <= 2'd0;
      third_pad_q <= 1'b0;
      bad_q       <= 1'b0;
      disc_q      <= 1'b0;
    end else if (fire_i) begin
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      third_pad_q <= third_pad_d;
      bad_q       <= bad_d;
      disc_q      <= disc_d;
    end
  end

endmodule

>>> design/b64sd_out_buf.sv
module b64sd_out_buf (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  b64sd_pkg::res_bundle_t  res_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              data_byte_o,
  output logic                    run_last_o,
  output logic                    message_end_o,
  output logic [1:0]              status_o
);
  import b64sd_pkg::*;

  logic [TripleW-1:0] triple_q;
  logic [1:0]         rem_q;
  logic [1:0]         idx_q;
  logic               me_q;
  status_e            status_q;
  logic               take;

  assign out_valid_o = (rem_q != 2'd0);
  assign take        = out_valid_o && !out_stall_i;
  // room for a new group once the last pending word leaves
  assign free_o      = (rem_q == 2'd0) || (rem_q == 2'd1 && take);

  always_comb begin
    case (idx_q)
      2'd0:    data_byte_o = triple_q[23:16];
      2'd1:    data_byte_o = triple_q[15:8];
      2'd2:    data_byte_o = triple_q[7:0];
      default: data_byte_o = '0;
    endcase
  end

  assign run_last_o    = (rem_q == 2'd1);
  assign message_end_o = (rem_q == 2'd1) && me_q;
  assign status_o      = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      rem_q <= res_i.count;
      idx_q <= 2'd0;
    end else if (take) begin
      rem_q <= rem_q - 2'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      triple_q <= res_i.triple;
      me_q     <= res_i.msg_end;
      status_q <= res_i.status;
    end
  end

endmodule

>>> design/base64_stream_decoder_top.sv
// base64 stream decoder (standard alphabet, '=' read as a zero sextet). One
// character word is taken per cycle, every cycle, as long as the output side
// keeps up: the character is registered, then mapped and merged into the
// quad state in one short pass that loads the output buffer. A complete quad
// gives three byte words (fewer on a padded final quad) that leave one per
// cycle while out_stall_i is low, so a steady character stream never stalls;
// the fourth character passes the input register, its bytes the output buffer.
// Errors come out as one word with data zero, message_end set and status
// bad-char or bad-length; after a bad-char error the rest of the message up
// to last_char is swallowed. Bytes already sent are not retracted, so a
// consumer should drop the message when an error word shows up.
module base64_stream_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       run_last_o,
  output logic       message_end_o,
  output logic [1:0] status_o
);
  import b64sd_pkg::*;

  // input register
  logic        s1_valid_q;
  logic [7:0]  s1_char_q;
  logic        s1_last_q;

  res_bundle_t res;
  logic        buf_free;
  logic        s1_adv;
  logic        in_take;

  // a character moves on when it makes no words or the buffer has room
  assign s1_adv     = s1_valid_q && ((res.count == 2'd0) || buf_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_char_q <= char_code_i;
      s1_last_q <= last_char_i;
    end
  end

  // alphabet map, quad accumulation and error tracking
  b64sd_quad_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_code_i (s1_char_q),
    .last_char_i (s1_last_q),
    .fire_i      (s1_adv),
    .res_o       (res)
  );

  // result register, sends the decoded bytes one word at a time
  b64sd_out_buf u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (s1_adv && (res.count != 2'd0)),
    .res_i         (res),
    .free_o        (buf_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_byte_o   (data_byte_o),
    .run_last_o    (run_last_o),
    .message_end_o (message_end_o),
    .status_o      (status_o)
  );

endmodule
